// ===== rtl/tgbp_pkg.sv =====
// tgbp_pkg: shared types, constants and sizes of the tagged geometric branch predictor
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package tgbp_pkg;

   localparam int BASE_ENTRIES_DEF = 2048;
   localparam int NUM_TABLES = 4;
   localparam int TBL_ENTRIES = 4096;
   localparam int IDX_W = 12;
   localparam int TAG_W = 8;
   localparam int CTR_W = 3;
   localparam int USE_W = 2;
   localparam int TC_W = TAG_W + CTR_W;
   localparam int PC_W = 32;
   localparam int HIST_W = 120;
   localparam int FOLD_N = 12;
   localparam int FOLD_MAX_W = 11;
   localparam int AGE_W = 18;
   localparam int PERIOD_W = 19;
   localparam int LFSR_W = 16;
   localparam int PROV_W = 3;

   localparam int HIST_LEN [NUM_TABLES] = '{8, 13, 32, 119};
   localparam int FOLD_W [FOLD_N] = '{8, 11, 11, 11, 8, 8, 8, 8, 7, 7, 7, 7};

   localparam logic [PROV_W-1:0] PROV_BASE = 3'd4;
   localparam logic [PROV_W-1:0] PROV_LAST = 3'd3;
   localparam logic [LFSR_W-1:0] LFSR_MASK = 16'hb400;
   localparam logic [LFSR_W-1:0] LFSR_SEED = 16'h0001;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 19'd262144;
   localparam logic [CTR_W-1:0] CTR_NEW_TAKEN = 3'd4;
   localparam logic [CTR_W-1:0] CTR_NEW_NOT_TAKEN = 3'd3;
   localparam logic [CTR_W-1:0] CTR_MAX = 3'd7;
   localparam logic [USE_W-1:0] USE_MAX = 2'd3;
   localparam logic [1:0] BASE_MAX = 2'd3;

   typedef struct packed {
      logic [PC_W-1:0] pc;
      logic taken;
      logic age;
      logic [NUM_TABLES-1:0][IDX_W-1:0] idx;
      logic [NUM_TABLES-1:0][TAG_W-1:0] tag;
   } tgbp_job_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_AGE
   } tgbp_state_type;

endpackage
`default_nettype wire

// ===== rtl/tagged_geometric_branch_predictor.sv =====
// Tagged geometric-history branch predictor: one branch per transfer, each one result.
// After reset all table entries are cleared in one sweep, during which
// req_stall is high. In the back end a branch is handled as a table read, then a
// counter write; front and back are parted by a two-entry queue and the result by an
// output register. When the useful age period runs out, one useful bit column of the
// tagged tables is cleared before the next branch is looked up. The
// period register should be written only while no branch is in flight.
// depends on tgbp_pkg, tgbp_front, tgbp_queue, tgbp_back, tgbp_ram
`timescale 1ns / 1ps
`default_nettype none
module tagged_geometric_branch_predictor
   import tgbp_pkg::*;
#(
   parameter int BASE_ENTRIES = BASE_ENTRIES_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [PC_W-1:0]     req_pc,
   input  wire logic                req_taken,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic                     rsp_predict_taken,
   output logic [PROV_W-1:0]        rsp_provider,
   output logic                     rsp_alternate_taken,
   output logic                     rsp_mispredicted,
   input  wire logic                csr_wr_en,
   input  wire logic [PERIOD_W-1:0] csr_wr_data
);

   tgbp_job_type push_job, head_job;
   logic push, full, pop, head_valid, clearing;

   tgbp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_pc      (req_pc),
      .req_taken   (req_taken),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_full      (full),
      .clearing    (clearing),
      .q_push      (push),
      .q_job       (push_job)
   );

   tgbp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   tgbp_back #(.BASE_ENTRIES(BASE_ENTRIES)) u_back (
      .clock               (clock),
      .reset               (reset),
      .q_valid             (head_valid),
      .q_job               (head_job),
      .q_pop               (pop),
      .clearing            (clearing),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_predict_taken   (rsp_predict_taken),
      .rsp_provider        (rsp_provider),
      .rsp_alternate_taken (rsp_alternate_taken),
      .rsp_mispredicted    (rsp_mispredicted)
   );

endmodule
`default_nettype wire

// ===== rtl/tgbp_ram.sv =====
// tgbp_ram: generic one-write one-read memory with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module tgbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

// ===== rtl/tgbp_front.sv =====
// tgbp_front: accepts branches, keeps global and folded history, forms indexes and tags
// depends on tgbp_pkg
`timescale 1ns / 1ps
`default_nettype none
module tgbp_front
   import tgbp_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [PC_W-1:0]     req_pc,
   input  wire logic                req_taken,
   input  wire logic                csr_wr_en,
   input  wire logic [PERIOD_W-1:0] csr_wr_data,
   input  wire logic                q_full,
   input  wire logic                clearing,
   output logic                     q_push,
   output tgbp_job_type             q_job
);

   logic [HIST_W-1:0] ghist_ff, ghist_in;
   logic [FOLD_MAX_W-1:0] fold_ff [FOLD_N];
   logic [FOLD_MAX_W-1:0] fold_in [FOLD_N];
   logic [AGE_W-1:0] age_ff, age_in;
   logic [PERIOD_W-1:0] period_ff;
   logic [PERIOD_W-1:0] age_sum;
   logic age_hit;

   assign req_stall = q_full | clearing;
   assign q_push = req_valid & ~req_stall;
   assign ghist_in = {ghist_ff[HIST_W-2:0], req_taken};

   assign age_sum = {1'b0, age_ff} + PERIOD_W'(1);
   assign age_hit = age_sum >= period_ff;
   assign age_in = age_hit ? '0 : age_sum[AGE_W-1:0];

   always_comb begin
      q_job = '0;
      q_job.pc = req_pc;
      q_job.taken = req_taken;
      q_job.age = age_hit;
      for (int t = 0; t < NUM_TABLES; t++) begin
         q_job.idx[t] = {1'b0, fold_ff[t]} ^ req_pc[IDX_W+1:2];
         q_job.tag[t] = fold_ff[NUM_TABLES+t][TAG_W-1:0]
                      ^ fold_ff[2*NUM_TABLES+t][TAG_W-1:0] ^ req_pc[TAG_W+1:2];
      end
   end

   for (genvar i = 0; i < FOLD_N; i++) begin : g_fold
      localparam int W = FOLD_W[i];
      localparam int L = HIST_LEN[i % NUM_TABLES];
      localparam int P = L % W;
      always_comb begin
         logic [FOLD_MAX_W-1:0] v;
         v = '0;
         v[W-1:0] = {fold_ff[i][W-2:0], req_taken ^ fold_ff[i][W-1]};
         v[P] = v[P] ^ ghist_ff[L-1];
         fold_in[i] = v;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ghist_ff <= '0;
         age_ff <= '0;
         period_ff <= PERIOD_RESET;
         for (int i = 0; i < FOLD_N; i++) begin
            fold_ff[i] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            period_ff <= csr_wr_data;
         end
         if (q_push) begin
            ghist_ff <= ghist_in;
            age_ff <= age_in;
            for (int i = 0; i < FOLD_N; i++) begin
               fold_ff[i] <= fold_in[i];
            end
         end
      end
   end

endmodule
`default_nettype wire

// ===== rtl/tgbp_queue.sv =====
// tgbp_queue: two-entry job queue between front and back
// depends on tgbp_pkg
`timescale 1ns / 1ps
`default_nettype none
module tgbp_queue
   import tgbp_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   push,
   input  wire tgbp_job_type push_job,
   output logic        full,
   input  wire logic   pop,
   output logic        head_valid,
   output tgbp_job_type head_job
);

   tgbp_job_type slot_ff [2];
   logic wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign full = count_ff == 2'd2;
   assign head_valid = count_ff != 2'd0;
   assign head_job = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

endmodule
`default_nettype wire

// ===== rtl/tgbp_back.sv =====
// tgbp_back: table lookup, counter training, allocation, useful aging and clearing
// depends on tgbp_pkg and tgbp_ram
`timescale 1ns / 1ps
`default_nettype none
module tgbp_back
   import tgbp_pkg::*;
#(
   parameter int BASE_ENTRIES = BASE_ENTRIES_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_valid,
   input  wire tgbp_job_type      q_job,
   output logic                   q_pop,
   output logic                   clearing,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic                   rsp_predict_taken,
   output logic [PROV_W-1:0]      rsp_provider,
   output logic                   rsp_alternate_taken,
   output logic                   rsp_mispredicted
);

   localparam int BIDX_W = $clog2(BASE_ENTRIES);
   localparam int SWEEP_N = (BASE_ENTRIES > TBL_ENTRIES) ? BASE_ENTRIES : TBL_ENTRIES;
   localparam int CNT_W = $clog2(SWEEP_N);

   tgbp_state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic clear_high_ff, clear_high_in;
   logic [LFSR_W-1:0] lfsr_ff, lfsr_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic pred_ff, pred_in, alt_ff, alt_in, misp_ff, misp_in;
   logic [PROV_W-1:0] prov_ff, prov_in;

   logic [1:0] base_rd, base_wd;
   logic base_we;
   logic [BIDX_W-1:0] base_wa;
   logic [TC_W-1:0] tc_rd [NUM_TABLES];
   logic [TC_W-1:0] tc_wd [NUM_TABLES];
   logic [NUM_TABLES-1:0] tc_we, uhi_we, ulo_we, uhi_rd, ulo_rd, uhi_wd, ulo_wd;
   logic [IDX_W-1:0] t_wa;
   logic [USE_W-1:0] use_wd [NUM_TABLES];
   logic [NUM_TABLES-1:0] u_we;

   logic out_free, sweep_last;

   function automatic logic [CTR_W-1:0] sat_ctr(input logic [CTR_W-1:0] v, input logic up);
      if (up) begin
         return (v == CTR_MAX) ? v : v + CTR_W'(1);
      end
      return (v == '0) ? v : v - CTR_W'(1);
   endfunction

   function automatic logic [USE_W-1:0] sat_use(input logic [USE_W-1:0] v, input logic up);
      if (up) begin
         return (v == USE_MAX) ? v : v + USE_W'(1);
      end
      return (v == '0) ? v : v - USE_W'(1);
   endfunction

   function automatic logic [1:0] sat_base(input logic [1:0] v, input logic up);
      if (up) begin
         return (v == BASE_MAX) ? v : v + 2'd1;
      end
      return (v == '0) ? v : v - 2'd1;
   endfunction

   // divisible by three: base-4 digit sums
   function automatic logic div3(input logic [LFSR_W-1:0] v);
      logic [4:0] s;
      logic [3:0] s2;
      logic [2:0] s3;
      s = '0;
      for (int d = 0; d < LFSR_W / 2; d++) begin
         s = s + 5'(v[2*d +: 2]);
      end
      s2 = 4'(s[4:2]) + 4'(s[1:0]);
      s3 = 3'(s2[3:2]) + 3'(s2[1:0]);
      return (s3 == 3'd0) || (s3 == 3'd3);
   endfunction

   tgbp_ram #(.WIDTH(2), .DEPTH(BASE_ENTRIES)) u_base (
      .clock   (clock),
      .wr_en   (base_we),
      .wr_addr (base_wa),
      .wr_data (base_wd),
      .rd_addr (q_job.pc[BIDX_W-1:0]),
      .rd_data (base_rd)
   );

   for (genvar t = 0; t < NUM_TABLES; t++) begin : g_tbl
      tgbp_ram #(.WIDTH(TC_W), .DEPTH(TBL_ENTRIES)) u_tc (
         .clock   (clock),
         .wr_en   (tc_we[t]),
         .wr_addr (state_ff == ST_EXEC ? q_job.idx[t] : t_wa),
         .wr_data (tc_wd[t]),
         .rd_addr (q_job.idx[t]),
         .rd_data (tc_rd[t])
      );
      tgbp_ram #(.WIDTH(1), .DEPTH(TBL_ENTRIES)) u_uhi (
         .clock   (clock),
         .wr_en   (uhi_we[t]),
         .wr_addr (state_ff == ST_EXEC ? q_job.idx[t] : t_wa),
         .wr_data (uhi_wd[t]),
         .rd_addr (q_job.idx[t]),
         .rd_data (uhi_rd[t])
      );
      tgbp_ram #(.WIDTH(1), .DEPTH(TBL_ENTRIES)) u_ulo (
         .clock   (clock),
         .wr_en   (ulo_we[t]),
         .wr_addr (state_ff == ST_EXEC ? q_job.idx[t] : t_wa),
         .wr_data (ulo_wd[t]),
         .rd_addr (q_job.idx[t]),
         .rd_data (ulo_rd[t])
      );
   end

   assign clearing = state_ff == ST_CLEAR;
   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign t_wa = IDX_W'(cnt_ff);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_predict_taken = pred_ff;
   assign rsp_provider = prov_ff;
   assign rsp_alternate_taken = alt_ff;
   assign rsp_mispredicted = misp_ff;

   always_comb begin
      logic [NUM_TABLES-1:0] hit, cand, free;
      logic [PROV_W-1:0] prov, alt;
      logic base_dir, pred, alt_dir, misp, have_first, have_second, alloc;
      logic [1:0] first, second, pick;
      logic [USE_W-1:0] use_t [NUM_TABLES];
      logic [LFSR_W-1:0] lfsr_step;

      state_in = state_ff;
      cnt_in = cnt_ff;
      clear_high_in = clear_high_ff;
      lfsr_in = lfsr_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      pred_in = pred_ff;
      alt_in = alt_ff;
      misp_in = misp_ff;
      prov_in = prov_ff;
      q_pop = 1'b0;
      base_we = 1'b0;
      base_wa = q_job.pc[BIDX_W-1:0];
      base_wd = '0;
      tc_we = '0;
      u_we = '0;
      uhi_we = '0;
      ulo_we = '0;
      uhi_wd = '0;
      ulo_wd = '0;
      sweep_last = 1'b0;
      for (int t = 0; t < NUM_TABLES; t++) begin
         tc_wd[t] = '0;
         use_wd[t] = '0;
      end

      // lookup
      base_dir = base_rd[1];
      prov = PROV_BASE;
      alt = PROV_BASE;
      for (int t = 0; t < NUM_TABLES; t++) begin
         hit[t] = tc_rd[t][TC_W-1:CTR_W] == q_job.tag[t];
         use_t[t] = {uhi_rd[t], ulo_rd[t]};
         if (hit[t]) begin
            prov = PROV_W'(t);
         end
      end
      for (int t = 0; t < NUM_TABLES; t++) begin
         if (hit[t] && PROV_W'(t) < prov) begin
            alt = PROV_W'(t);
         end
      end
      pred = (prov == PROV_BASE) ? base_dir : tc_rd[prov[1:0]][CTR_W-1];
      alt_dir = (alt == PROV_BASE) ? base_dir : tc_rd[alt[1:0]][CTR_W-1];
      misp = pred != q_job.taken;

      // allocation candidates
      have_first = 1'b0;
      have_second = 1'b0;
      first = '0;
      second = '0;
      for (int t = 0; t < NUM_TABLES; t++) begin
         cand[t] = (prov == PROV_BASE) || (PROV_W'(t) > prov);
         free[t] = cand[t] && (use_t[t] == '0);
         if (free[t]) begin
            if (!have_first) begin
               have_first = 1'b1;
               first = 2'(t);
            end else if (!have_second) begin
               have_second = 1'b1;
               second = 2'(t);
            end
         end
      end
      alloc = misp && (prov != PROV_LAST);
      lfsr_step = (lfsr_ff >> 1) ^ (lfsr_ff[0] ? LFSR_MASK : '0);
      pick = (have_second && div3(lfsr_step)) ? second : first;

      unique case (state_ff)
         ST_CLEAR: begin
            sweep_last = cnt_ff == CNT_W'(SWEEP_N - 1);
            base_we = {1'b0, cnt_ff} < (CNT_W+1)'(BASE_ENTRIES);
            base_wa = BIDX_W'(cnt_ff);
            for (int t = 0; t < NUM_TABLES; t++) begin
               tc_we[t] = {1'b0, cnt_ff} < (CNT_W+1)'(TBL_ENTRIES);
               uhi_we[t] = tc_we[t];
               ulo_we[t] = tc_we[t];
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (sweep_last) begin
               state_in = ST_IDLE;
               cnt_in = '0;
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               q_pop = 1'b1;
               rsp_valid_in = 1'b1;
               pred_in = pred;
               alt_in = alt_dir;
               prov_in = prov;
               misp_in = misp;
               if (prov == PROV_BASE) begin
                  base_we = 1'b1;
                  base_wd = sat_base(base_rd, q_job.taken);
               end
               for (int t = 0; t < NUM_TABLES; t++) begin
                  if (prov == PROV_W'(t)) begin
                     tc_we[t] = 1'b1;
                     tc_wd[t] = {tc_rd[t][TC_W-1:CTR_W],
                                 sat_ctr(tc_rd[t][CTR_W-1:0], q_job.taken)};
                     u_we[t] = pred != alt_dir;
                     use_wd[t] = sat_use(use_t[t], pred == q_job.taken);
                  end
               end
               if (alloc) begin
                  if (!have_first) begin
                     for (int t = 0; t < NUM_TABLES; t++) begin
                        if (cand[t]) begin
                           u_we[t] = 1'b1;
                           use_wd[t] = sat_use(use_t[t], 1'b0);
                        end
                     end
                  end else begin
                     lfsr_in = lfsr_step;
                     tc_we[pick] = 1'b1;
                     tc_wd[pick] = {q_job.tag[pick],
                                    q_job.taken ? CTR_NEW_TAKEN : CTR_NEW_NOT_TAKEN};
                     u_we[pick] = 1'b1;
                     use_wd[pick] = '0;
                  end
               end
               for (int t = 0; t < NUM_TABLES; t++) begin
                  uhi_we[t] = u_we[t];
                  ulo_we[t] = u_we[t];
                  uhi_wd[t] = use_wd[t][1];
                  ulo_wd[t] = use_wd[t][0];
               end
               cnt_in = '0;
               state_in = q_job.age ? ST_AGE : ST_IDLE;
            end
         end
         ST_AGE: begin
            // clear one useful bit column of every tagged entry
            sweep_last = cnt_ff == CNT_W'(TBL_ENTRIES - 1);
            for (int t = 0; t < NUM_TABLES; t++) begin
               uhi_we[t] = clear_high_ff;
               ulo_we[t] = ~clear_high_ff;
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (sweep_last) begin
               state_in = ST_IDLE;
               cnt_in = '0;
               clear_high_in = ~clear_high_ff;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff <= '0;
         clear_high_ff <= 1'b1;
         lfsr_ff <= LFSR_SEED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         clear_high_ff <= clear_high_in;
         lfsr_ff <= lfsr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pred_ff <= pred_in;
      alt_ff <= alt_in;
      prov_ff <= prov_in;
      misp_ff <= misp_in;
   end

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// testbench for tagged_geometric_branch_predictor: random and directed branches,
// checked against a behavioral predictor kept in a scoreboard class
// depends on tgbp_pkg and the rtl of the block
`timescale 1ns / 1ps
module testbench;
   import tgbp_pkg::*;

   class tage_scoreboard;
      logic [1:0] base_ctr [BASE_ENTRIES_DEF];
      logic [12:0] entry [NUM_TABLES*TBL_ENTRIES];
      logic [HIST_W-1:0] ghist;
      logic [10:0] fold [FOLD_N];
      logic [AGE_W-1:0] age_count;
      logic [PERIOD_W-1:0] period;
      logic clear_high;
      logic [LFSR_W-1:0] lfsr;
      logic [5:0] pending [$];
      int errors;
      int checked;
      int agings;

      function new();
         foreach (base_ctr[i]) base_ctr[i] = 0;
         foreach (entry[i]) entry[i] = 0;
         foreach (fold[i]) fold[i] = 0;
         ghist = 0;
         age_count = 0;
         period = PERIOD_RESET;
         clear_high = 1;
         lfsr = LFSR_SEED;
         errors = 0;
         checked = 0;
         agings = 0;
      endfunction

      function logic [1:0] sat2(logic [1:0] v, logic up);
         if (up) return (v == 2'd3) ? v : v + 2'd1;
         return (v == 2'd0) ? v : v - 2'd1;
      endfunction

      function logic [2:0] sat3(logic [2:0] v, logic up);
         if (up) return (v == CTR_MAX) ? v : v + 3'd1;
         return (v == 3'd0) ? v : v - 3'd1;
      endfunction

      // one branch: predict, train, allocate, age, shift history
      function void note_branch(logic [PC_W-1:0] pc, logic taken);
         int slot [NUM_TABLES];
         logic [TAG_W-1:0] tg [NUM_TABLES];
         int bidx, prov, alt, start, first, second, pick;
         logic bpred, pred, apred, hf, hs;
         logic [12:0] e;
         logic [1:0] u;
         logic [1:0] keep;
         logic top;
         int w, len;
         bidx = pc % BASE_ENTRIES_DEF;
         bpred = base_ctr[bidx] >= 2;
         for (int t = 0; t < NUM_TABLES; t++) begin
            slot[t] = t * TBL_ENTRIES + ((fold[t] ^ pc[13:2]) & 12'hfff);
            tg[t] = fold[4+t][7:0] ^ fold[8+t][7:0] ^ pc[9:2];
         end
         prov = PROV_BASE;
         alt = PROV_BASE;
         for (int t = 3; t >= 0; t--)
            if (prov == PROV_BASE && entry[slot[t]][7:0] == tg[t]) prov = t;
         if (prov != PROV_BASE)
            for (int t = prov - 1; t >= 0; t--)
               if (alt == PROV_BASE && entry[slot[t]][7:0] == tg[t]) alt = t;
         apred = (alt == PROV_BASE) ? bpred : entry[slot[alt]][10];
         pred = (prov == PROV_BASE) ? bpred : entry[slot[prov]][10];
         if (prov != PROV_BASE) begin
            e = entry[slot[prov]];
            u = e[12:11];
            if (pred != apred) u = sat2(u, pred == taken);
            entry[slot[prov]] = {u, sat3(e[10:8], taken), e[7:0]};
         end else begin
            base_ctr[bidx] = sat2(base_ctr[bidx], taken);
         end
         if (pred != taken && prov != PROV_LAST) begin
            start = (prov == PROV_BASE) ? 0 : prov + 1;
            hf = 0;
            hs = 0;
            first = 0;
            second = 0;
            for (int t = start; t < NUM_TABLES; t++)
               if (!hs && entry[slot[t]][12:11] == 0) begin
                  if (!hf) begin
                     hf = 1;
                     first = t;
                  end else begin
                     hs = 1;
                     second = t;
                  end
               end
            if (!hf) begin
               for (int t = start; t < NUM_TABLES; t++)
                  entry[slot[t]][12:11] = sat2(entry[slot[t]][12:11], 1'b0);
            end else begin
               lfsr = lfsr[0] ? ((lfsr >> 1) ^ LFSR_MASK) : (lfsr >> 1);
               pick = (hs && (lfsr % 3) == 0) ? second : first;
               entry[slot[pick]] = {2'b00, taken ? CTR_NEW_TAKEN : CTR_NEW_NOT_TAKEN,
                                    tg[pick]};
            end
         end
         if ({1'b0, age_count} + 1 >= period) begin
            keep = clear_high ? 2'b01 : 2'b10;
            age_count = 0;
            foreach (entry[s]) entry[s][12:11] = entry[s][12:11] & keep;
            clear_high = !clear_high;
            agings++;
         end else begin
            age_count = age_count + 18'd1;
         end
         ghist = {ghist[HIST_W-2:0], taken};
         for (int t = 0; t < FOLD_N; t++) begin
            w = FOLD_W[t];
            len = HIST_LEN[t % 4];
            top = fold[t][w-1];
            fold[t] = (fold[t] << 1) & ((11'd1 << w) - 1);
            fold[t][0] = taken ^ top;
            fold[t] = fold[t] ^ (11'(ghist[len]) << (len % w));
         end
         pending.push_back({pred, 3'(prov), apred, pred != taken});
      endfunction

      function void check_result(logic [5:0] got);
         logic [5:0] want;
         checked++;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %b", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got[5] !== want[5])
            $display("%0t: predict_taken expected %b actual %b", $time, want[5], got[5]);
         if (got[4:2] !== want[4:2])
            $display("%0t: provider expected %0d actual %0d", $time, want[4:2], got[4:2]);
         if (got[1] !== want[1])
            $display("%0t: alternate_taken expected %b actual %b", $time, want[1], got[1]);
         if (got[0] !== want[0])
            $display("%0t: mispredicted expected %b actual %b", $time, want[0], got[0]);
         if (got !== want) errors++;
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [PC_W-1:0] req_pc;
   logic req_taken;
   logic rsp_valid;
   logic rsp_stall;
   logic rsp_predict_taken;
   logic [PROV_W-1:0] rsp_provider;
   logic rsp_alternate_taken;
   logic rsp_mispredicted;
   logic csr_wr_en;
   logic [PERIOD_W-1:0] csr_wr_data;

   tage_scoreboard board;
   longint cycles = 0;
   int branches;
   bit rsp_pause;

   tagged_geometric_branch_predictor dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_pc(req_pc),
      .req_taken(req_taken),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_predict_taken(rsp_predict_taken),
      .rsp_provider(rsp_provider),
      .rsp_alternate_taken(rsp_alternate_taken),
      .rsp_mispredicted(rsp_mispredicted),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   function int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // the limit covers the clearing pass and one aging walk per branch
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 12000000) begin
         $display("timeout after %0d cycles", cycles);
         $display("simulation failed");
         $finish;
      end
   end

   // result side: check every transfer, random stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_result({rsp_predict_taken, rsp_provider, rsp_alternate_taken,
                             rsp_mispredicted});
   end

   initial begin
      int g;
      rsp_stall = 1;
      wait (board != null);
      @(negedge clock);
      forever begin
         if (rsp_pause) begin
            rsp_stall <= 0;
            @(negedge clock);
         end else begin
            g = gap_length();
            rsp_stall <= (g != 0);
            repeat (g == 0 ? $urandom_range(1, 6) : g) @(negedge clock);
         end
      end
   end

   task send_branch(logic [PC_W-1:0] pc, logic taken);
      req_valid <= 1;
      req_pc <= pc;
      req_taken <= taken;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_branch(pc, taken);
      branches++;
      @(negedge clock);
   endtask

   task send_gap();
      int g;
      g = gap_length();
      if (g != 0) begin
         req_valid <= 0;
         repeat (g) @(negedge clock);
      end
   endtask

   task drain_and_write(logic [PERIOD_W-1:0] value);
      req_valid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      csr_wr_en <= 1;
      csr_wr_data <= value;
      board.period = value;
      @(negedge clock);
      csr_wr_en <= 0;
   endtask

   // a short loop of branches with a fixed pattern, random content
   task send_pattern(int count);
      logic [PC_W-1:0] base_pc;
      logic [7:0] pattern;
      int len;
      base_pc = $urandom;
      pattern = $urandom;
      len = $urandom_range(1, 6);
      for (int i = 0; i < count; i++) begin
         send_branch(base_pc + 4 * (i % len), pattern[i % 8]);
         send_gap();
      end
   endtask

   initial begin
      logic [PERIOD_W-1:0] periods [5];
      board = new();
      branches = 0;
      rsp_pause = 0;
      reset = 1;
      req_valid = 0;
      req_pc = 0;
      req_taken = 0;
      csr_wr_en = 0;
      csr_wr_data = 0;
      repeat (5) @(negedge clock);
      reset <= 0;

      // directed: field extremes, repeated mispredicts to fill tagged tables
      send_branch(32'h0000_0000, 1'b0);
      send_branch(32'hffff_ffff, 1'b1);
      send_branch(32'h0000_0000, 1'b1);
      send_branch(32'hffff_ffff, 1'b0);
      send_branch(32'haaaa_aaaa, 1'b1);
      send_branch(32'h5555_5555, 1'b0);
      for (int i = 0; i < 12; i++) send_branch(32'h0000_1000, i[0]);
      for (int i = 0; i < 6; i++) send_branch(32'h8000_0004, i % 3 == 0);

      // phases with different aging periods, extremes included
      periods = '{19'd1, 19'd262144, 19'd3, 19'd0, 19'h7ffff};
      foreach (periods[p]) begin
         drain_and_write(periods[p]);
         for (int k = 0; k < 160; k += 20) begin
            if ($urandom_range(0, 3) == 0) begin
               for (int j = 0; j < 20; j++) begin
                  send_branch($urandom, $urandom_range(0, 1));
                  send_gap();
               end
            end else begin
               send_pattern(20);
            end
         end
      end
      drain_and_write(19'd100);
      send_pattern(40);

      req_valid <= 0;
      rsp_pause = 1;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      $display("%0d branches sent, %0d results checked, %0d aging passes",
               branches, board.checked, board.agings);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
